FILE: src/cgw_pkg.sv
`default_nettype none
package cgw_pkg;

    localparam int MAX_J = 3;

    typedef logic signed [5:0] t_sarg;

    typedef struct packed {
        logic              rule_zero;
        logic              three_j;
        logic [1:0]        j1;
        logic signed [2:0] m1;
        logic [1:0]        j2;
        logic signed [2:0] m2;
        logic [1:0]        jt;
        logic signed [3:0] mc;
        logic signed [4:0] lo;
        logic signed [4:0] hi;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM_MUL,
        S_TERM_WB,
        S_TERM_DIV,
        S_TERM_ACC,
        S_SQ,
        S_SQ_WB,
        S_F_LO,
        S_F_HI,
        S_F_ADD,
        S_DIV_INIT,
        S_DIV,
        S_ROOT,
        S_ROUND,
        S_DONE
    } t_state;

    function automatic logic [21:0] fct(input t_sarg k);
        logic [21:0] f;
        f = 22'd3628800;
        if (k < 0) begin
            f = 22'd1;
        end else if (k <= 6'sd10) begin
            case (k[3:0])
                4'd0:    f = 22'd1;
                4'd1:    f = 22'd1;
                4'd2:    f = 22'd2;
                4'd3:    f = 22'd6;
                4'd4:    f = 22'd24;
                4'd5:    f = 22'd120;
                4'd6:    f = 22'd720;
                4'd7:    f = 22'd5040;
                4'd8:    f = 22'd40320;
                4'd9:    f = 22'd362880;
                default: f = 22'd3628800;
            endcase
        end
        return f;
    endfunction

    function automatic logic signed [4:0] iabs5(input logic signed [4:0] v);
        return (v < 0) ? -v : v;
    endfunction

endpackage
`default_nettype wire

FILE: src/cgw_front.sv
`default_nettype none
module cgw_front import cgw_pkg::*; (
    input  wire logic              i_func,
    input  wire logic [1:0]        i_j_one,
    input  wire logic signed [2:0] i_m_one,
    input  wire logic [1:0]        i_j_two,
    input  wire logic signed [2:0] i_m_two,
    input  wire logic [1:0]        i_j_total,
    input  wire logic signed [2:0] i_m_total,
    output t_item                  o_item
);

    logic signed [4:0] j1, j2, jt, m1, m2, mt, mc, a, hi, lo;
    logic              ok;

    always_comb begin
        j1 = {3'b0, i_j_one};
        j2 = {3'b0, i_j_two};
        jt = {3'b0, i_j_total};
        m1 = {{2{i_m_one[2]}}, i_m_one};
        m2 = {{2{i_m_two[2]}}, i_m_two};
        mt = {{2{i_m_total[2]}}, i_m_total};
        mc = i_func ? -mt : mt;
        a  = j1 + j2 - jt;

        ok = (j1 <= 5'(MAX_J)) && (j2 <= 5'(MAX_J)) && (jt <= 5'(MAX_J))
            && (jt >= iabs5(j1 - j2)) && (jt <= j1 + j2)
            && (iabs5(m1) <= j1) && (iabs5(m2) <= j2) && (iabs5(mc) <= jt)
            && (m1 + m2 == mc);

        hi = a;
        if (j1 - m1 < hi) hi = j1 - m1;
        if (j2 + m2 < hi) hi = j2 + m2;
        lo = 5'sd0;
        if (j2 - jt - m1 > lo) lo = j2 - jt - m1;
        if (j1 - jt + m2 > lo) lo = j1 - jt + m2;

        o_item.rule_zero = !ok;
        o_item.three_j   = i_func;
        o_item.j1        = i_j_one;
        o_item.m1        = i_m_one;
        o_item.j2        = i_j_two;
        o_item.m2        = i_m_two;
        o_item.jt        = i_j_total;
        o_item.mc        = mc[3:0];
        o_item.lo        = lo;
        o_item.hi        = hi;
    end

endmodule
`default_nettype wire

FILE: src/cgw_queue.sv
`default_nettype none
module cgw_queue import cgw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    input  wire logic  i_pop,
    output t_item      o_data,
    output logic       o_valid,
    output logic       o_full
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule
`default_nettype wire

FILE: src/cgw_back.sv
`default_nettype none
module cgw_back import cgw_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_item        i_item,
    input  wire logic         i_valid,
    output logic              o_pop,
    output logic              o_strobe,
    output logic signed [31:0] o_coeff_value,
    output logic              o_rule_zero
);

    t_state             r_state, n_state;
    t_item              r_it;
    logic signed [4:0]  r_t;
    logic [5:0]         r_cnt;
    logic signed [21:0] r_acc;
    logic [21:0]        r_d;
    logic [18:0]        r_dvd, r_quo;
    logic [22:0]        r_rem;
    logic [53:0]        r_mul, r_plo;
    logic [63:0]        r_x, r_y, r_r;
    logic [59:0]        r_q, r_v, r_res, r_bit;
    logic [30:0]        r_mag;
    logic               r_rz, r_neg;
    logic               r_strobe, r_rzo;
    logic signed [31:0] r_coeff;

    logic [31:0]        mul_a;
    logic [21:0]        mul_b;
    logic [53:0]        mul_p;
    t_sarg              j1s, j2s, jts, m1s, m2s, mcs, ts, ks, targ, farg;
    logic [21:0]        fval, f2j, fct_k;
    logic [63:0]        tgt, fsum, rr;
    logic [20:0]        ap;
    logic signed [21:0] acc_abs;
    logic [22:0]        rem_sh;
    logic               dbit, qbit, rbit, up, flip;
    logic [59:0]        rsum, n_ext;

    always_comb begin
        j1s = {4'b0, r_it.j1};
        j2s = {4'b0, r_it.j2};
        jts = {4'b0, r_it.jt};
        m1s = {{3{r_it.m1[2]}}, r_it.m1};
        m2s = {{3{r_it.m2[2]}}, r_it.m2};
        mcs = {{2{r_it.mc[3]}}, r_it.mc};
        ts  = {r_t[4], r_t};
        ks  = j1s + j2s + jts;
        fct_k = fct(ks);
        f2j = {19'b0, r_it.jt, 1'b1};

        case (r_cnt[2:0])
            3'd1:    targ = j1s + j2s - jts - ts;
            3'd2:    targ = j1s - m1s - ts;
            3'd3:    targ = j2s + m2s - ts;
            3'd4:    targ = jts - j2s + m1s + ts;
            3'd5:    targ = jts - j1s - m2s + ts;
            default: targ = ts;
        endcase

        case (r_cnt[3:0])
            4'd0:    farg = j1s + m1s;
            4'd1:    farg = j1s - m1s;
            4'd2:    farg = j2s + m2s;
            4'd3:    farg = j2s - m2s;
            4'd4:    farg = jts + mcs;
            4'd5:    farg = jts - mcs;
            4'd6:    farg = j1s + j2s - jts;
            4'd7:    farg = j1s - j2s + jts;
            4'd8:    farg = j2s + jts - j1s;
            4'd12:   farg = ks + 6'sd1;
            default: farg = ks;
        endcase

        if (r_cnt[3:0] == 4'd9) begin
            fval = r_it.three_j ? 22'd1 : f2j;
        end else if (r_cnt[3:0] == 4'd13) begin
            fval = r_it.three_j ? f2j : 22'd1;
        end else begin
            fval = fct(farg);
        end

        tgt     = (r_cnt < 6'd10) ? r_x : r_y;
        fsum    = {r_mul[31:0], 32'b0} + {10'b0, r_plo};
        acc_abs = (r_acc < 0) ? -r_acc : r_acc;
        ap      = acc_abs[20:0];

        rem_sh  = {r_rem[21:0], r_dvd[18]};
        dbit    = (rem_sh >= {1'b0, r_d});
        rr      = {r_r[62:0], 1'b0};
        qbit    = (rr >= r_y);
        rsum    = r_res + r_bit;
        rbit    = (r_v >= rsum);
        n_ext   = {29'b0, r_res[30:0]};
        up      = (r_v >= n_ext + 60'd1)
            || ((r_v == n_ext) && ({r_r[61:0], 2'b0} >= r_y));
        flip    = r_it.three_j & (r_it.j1[0] ^ r_it.j2[0] ^ r_it.mc[0]);
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.rule_zero)          n_state = S_DONE;
                    else if (i_item.lo > i_item.hi) n_state = S_SQ;
                    else                            n_state = S_TERM_MUL;
                end
            end
            S_TERM_MUL: n_state = S_TERM_WB;
            S_TERM_WB:  n_state = (r_cnt == 6'd5) ? S_TERM_DIV : S_TERM_MUL;
            S_TERM_DIV: n_state = (r_cnt == 6'd18) ? S_TERM_ACC : S_TERM_DIV;
            S_TERM_ACC: n_state = (r_t >= r_it.hi) ? S_SQ : S_TERM_MUL;
            S_SQ:       n_state = (ap == 21'd0) ? S_DONE : S_SQ_WB;
            S_SQ_WB:    n_state = S_F_LO;
            S_F_LO:     n_state = S_F_HI;
            S_F_HI:     n_state = S_F_ADD;
            S_F_ADD:    n_state = (r_cnt == 6'd13) ? S_DIV_INIT : S_F_LO;
            S_DIV_INIT: n_state = (r_x >= r_y) ? S_DONE : S_DIV;
            S_DIV:      n_state = (r_cnt == 6'd59) ? S_ROOT : S_DIV;
            S_ROOT:     n_state = (r_cnt == 6'd29) ? S_ROUND : S_ROOT;
            S_ROUND:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_IDLE:     o_pop = i_valid;
            S_TERM_MUL: begin
                mul_a = {10'b0, r_d};
                mul_b = fct(targ);
            end
            S_SQ: begin
                mul_a = {11'b0, ap};
                mul_b = {1'b0, ap};
            end
            S_F_LO: begin
                mul_a = tgt[31:0];
                mul_b = fval;
            end
            S_F_HI: begin
                mul_a = tgt[63:32];
                mul_b = fval;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_it  <= i_item;
                    r_t   <= i_item.lo;
                    r_acc <= '0;
                    r_d   <= 22'd1;
                    r_cnt <= '0;
                    r_rz  <= i_item.rule_zero;
                    r_mag <= '0;
                    r_neg <= 1'b0;
                end
            end
            S_TERM_WB: begin
                r_d <= r_mul[21:0];
                if (r_cnt == 6'd5) begin
                    r_cnt <= '0;
                    r_dvd <= fct_k[18:0];
                    r_rem <= '0;
                    r_quo <= '0;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            S_TERM_DIV: begin
                r_rem <= dbit ? (rem_sh - {1'b0, r_d}) : rem_sh;
                r_quo <= {r_quo[17:0], dbit};
                r_dvd <= {r_dvd[17:0], 1'b0};
                r_cnt <= (r_cnt == 6'd18) ? 6'd0 : r_cnt + 6'd1;
            end
            S_TERM_ACC: begin
                if (r_t[0]) r_acc <= r_acc - $signed({3'b0, r_quo});
                else        r_acc <= r_acc + $signed({3'b0, r_quo});
                r_t   <= r_t + 5'sd1;
                r_d   <= 22'd1;
                r_cnt <= '0;
            end
            S_SQ: begin
                r_neg <= (r_acc < 0) ^ flip;
            end
            S_SQ_WB: begin
                r_x   <= {22'b0, r_mul[41:0]};
                r_y   <= 64'd1;
                r_cnt <= '0;
            end
            S_F_HI: begin
                r_plo <= r_mul;
            end
            S_F_ADD: begin
                if (r_cnt < 6'd10) r_x <= fsum;
                else               r_y <= fsum;
                r_cnt <= (r_cnt == 6'd13) ? 6'd0 : r_cnt + 6'd1;
            end
            S_DIV_INIT: begin
                r_r   <= r_x;
                r_q   <= '0;
                r_cnt <= '0;
                if (r_x >= r_y) r_mag <= 31'h4000_0000;
            end
            S_DIV: begin
                r_r <= qbit ? (rr - r_y) : rr;
                r_q <= {r_q[58:0], qbit};
                if (r_cnt == 6'd59) begin
                    r_cnt <= '0;
                    r_v   <= {r_q[58:0], qbit};
                    r_res <= '0;
                    r_bit <= 60'd1 << 58;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            S_ROOT: begin
                if (rbit) begin
                    r_v   <= r_v - rsum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
            end
            S_ROUND: begin
                r_mag <= up ? (r_res[30:0] + 31'd1) : r_res[30:0];
            end
            S_DONE: begin
                r_coeff <= r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
                r_rzo   <= r_rz;
            end
            default: ;
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_coeff_value = r_coeff;
    assign o_rule_zero   = r_rzo;

endmodule
`default_nettype wire

FILE: src/clebsch_gordan_wigner_3j_top.sv
`default_nettype none
// Computes a Clebsch-Gordan coefficient (func 0) or a Wigner 3j symbol (func 1) for integer
// angular momenta up to three, as a signed Q2.30 word rounded to nearest. A word is taken at
// a rising edge with start high and busy low; a two-word queue sits between the classifying
// front end and the arithmetic back end, so busy rises only when two words are waiting. Each
// result is held on the result ports until the next one and is marked by o_strobe for one
// cycle, and the receiver cannot stall it. A word that breaks a selection rule gives zero with
// o_rule_zero set, the back end going from idle straight to its done state. Otherwise each of
// the T Racah terms (one to four) takes six table multiplies, each a multiply state and a
// write-back state, a 19-step divider and an accumulate; the squared magnitude then takes
// fourteen multiplies, each a low-half, a high-half and an add state, all on one shared 32 by
// 22 bit multiplier, followed by the 60-step fraction division and the 30-step square root. A
// sum that cancels or has no terms finishes right after squaring, and a magnitude of exactly
// one skips the division and the root.
module clebsch_gordan_wigner_3j_top import cgw_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [1:0]         i_j_one,
    input  wire logic signed [2:0]  i_m_one,
    input  wire logic [1:0]         i_j_two,
    input  wire logic signed [2:0]  i_m_two,
    input  wire logic [1:0]         i_j_total,
    input  wire logic signed [2:0]  i_m_total,
    output logic                    o_strobe,
    output logic signed [31:0]      o_coeff_value,
    output logic                    o_rule_zero
);

    t_item front_item, queue_item;
    logic  queue_valid, queue_full, pop;

    cgw_front u_front (
        .i_func    (i_func),
        .i_j_one   (i_j_one),
        .i_m_one   (i_m_one),
        .i_j_two   (i_j_two),
        .i_m_two   (i_m_two),
        .i_j_total (i_j_total),
        .i_m_total (i_m_total),
        .o_item    (front_item)
    );

    cgw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start & ~queue_full),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_data  (queue_item),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    cgw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (queue_item),
        .i_valid       (queue_valid),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_coeff_value (o_coeff_value),
        .o_rule_zero   (o_rule_zero)
    );

    assign busy = queue_full;

`ifndef SYNTH
    a_rule_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rule_zero) |-> (o_coeff_value == 32'sd0))
        else $error("Rule violation result is not zero.");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_coeff_value <= 32'sd1073741824)
            && (o_coeff_value >= -32'sd1073741824)))
        else $error("Coefficient outside the unit range.");

    a_reset_quiet: assert property (@(posedge i_clk)
        (!i_rst_n) |=> !o_strobe)
        else $error("Result strobe after reset.");
`endif

endmodule
`default_nettype wire
